// ===== rtl/core/rd_pkg.sv =====
package rd_pkg;

    // Default operand width of the divider
    localparam int DATA_WIDTH_DEF = 32;

endpackage

// ===== rtl/core/rd_stage.sv =====
// One quotient bit of the restoring division, with its own register and valid bit.
// Holds while the next stage is full and stalled; accepts a new item when empty or draining.
module rd_stage
    import rd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // upstream side
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_num,   // dividend bits not yet used, next bit on top
    input  logic [DATA_WIDTH-1:0] in_den,
    input  logic [DATA_WIDTH-1:0] in_part,  // partial remainder
    input  logic [DATA_WIDTH-1:0] in_quo,   // quotient bits so far, newest in bit 0
    // downstream side
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_num,
    output logic [DATA_WIDTH-1:0] out_den,
    output logic [DATA_WIDTH-1:0] out_part,
    output logic [DATA_WIDTH-1:0] out_quo
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] part_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] num_next;
    logic [DATA_WIDTH-1:0] part_next;
    logic [DATA_WIDTH-1:0] quo_next;
    logic                  carry;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    logic                  load;

    // Handshake: empty or draining stage takes a new item
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Shift in the next dividend bit; subtract when the divisor fits
    always_comb
    begin
        carry     = in_part[DATA_WIDTH-1];
        shifted   = {in_part[DATA_WIDTH-2:0], in_num[DATA_WIDTH-1]};
        diff      = {1'b0, shifted} - {1'b0, in_den};
        fits      = carry || !diff[DATA_WIDTH];
        part_next = fits ? diff[DATA_WIDTH-1:0] : shifted;
        quo_next  = {in_quo[DATA_WIDTH-2:0], fits};
        num_next  = {in_num[DATA_WIDTH-2:0], 1'b0};
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg  <= num_next;
            den_reg  <= in_den;
            part_reg <= part_next;
            quo_reg  <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_part  = part_reg;
    assign out_quo   = quo_reg;

endmodule

// ===== rtl/core/restoring_divider.sv =====
// Unsigned restoring divider, fully pipelined: one stage per quotient bit, so DATA_WIDTH
// register stages from input to output. A new division can be accepted every cycle while the
// output is not stalled; each stage does one (DATA_WIDTH+1)-bit subtract and select, which
// sets the clock limit. Every stage has its own valid bit and stalls only when it and the
// stage after it are both full, so bubbles close up behind a stalled output.
// Divide by zero gives an all-ones quotient and a remainder equal to the dividend.
module restoring_divider
    import rd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int TDATA_W   = ((2 * DATA_WIDTH + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input transfer
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // dividend, divisor (from bit 0), zero pad on top
    // result transfer
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // quotient, remainder (from bit 0), zero pad on top
);

    logic                  valid [DATA_WIDTH+1];
    logic                  ready [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] num   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] den   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] part  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] quo   [DATA_WIDTH+1];

    // Pipeline entry: unpack operands, start from a zero partial remainder
    assign valid[0] = s_tvalid;
    assign s_tready = ready[0];
    assign num[0]   = s_tdata[DATA_WIDTH-1:0];
    assign den[0]   = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign part[0]  = '0;
    assign quo[0]   = '0;

    // One stage per quotient bit, most significant first
    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_stage
        rd_stage #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[i]),
            .in_ready  (ready[i]),
            .in_num    (num[i]),
            .in_den    (den[i]),
            .in_part   (part[i]),
            .in_quo    (quo[i]),
            .out_valid (valid[i+1]),
            .out_ready (ready[i+1]),
            .out_num   (num[i+1]),
            .out_den   (den[i+1]),
            .out_part  (part[i+1]),
            .out_quo   (quo[i+1])
        );
    end

    // Last stage register is the output register
    assign ready[DATA_WIDTH] = m_tready;
    assign m_tvalid          = valid[DATA_WIDTH];
    assign m_tdata           = TDATA_W'({part[DATA_WIDTH], quo[DATA_WIDTH]});

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import rd_pkg::*;

    localparam int W         = DATA_WIDTH_DEF;
    localparam int TW        = ((2 * W + 7) / 8) * 8;
    localparam int N_RANDOM  = 850;
    localparam int MAX_WAIT  = 13;
    localparam int CYCLE_CAP = 400000;

    // one division waiting to go out; drain_first holds it back until the pipe is empty
    typedef struct {
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        logic         drain_first;
    } division_t;

    typedef struct {
        logic [W-1:0] quotient;
        logic [W-1:0] remainder;
    } quot_rem_t;

    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [TW-1:0] s_tdata  = '0;     // dividend, divisor (from bit 0)
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [TW-1:0] m_tdata;           // quotient, remainder (from bit 0)

    division_t   division_queue[$];
    quot_rem_t   quot_rem_due[$];

    int          send_gap    = 0;
    int          send_burst  = 0;
    int          recv_stall  = 0;
    int          recv_burst  = 0;
    int          stall_now;
    int          next_gap;
    division_t   head;
    quot_rem_t   got;
    quot_rem_t   want;

    int unsigned error_count   = 0;
    int unsigned sent_count    = 0;
    int unsigned checked_count = 0;
    int unsigned zero_count    = 0;
    int unsigned topbit_count  = 0;
    int unsigned drain_count   = 0;
    int unsigned cycle_count   = 0;

    restoring_divider uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock, period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // bit-serial restoring division with a trial value one bit wider than the operands;
    // a zero divisor always fits, which gives an all-ones quotient
    function automatic quot_rem_t divide_restoring(logic [W-1:0] num, logic [W-1:0] den);
        quot_rem_t r;
        logic [W:0] trial;
        logic [W-1:0] part;
        part = '0;
        r.quotient = '0;
        for (int b = W - 1; b >= 0; b--)
        begin
            trial = {part, num[b]};
            if (trial >= {1'b0, den})
            begin
                trial = trial - {1'b0, den};
                r.quotient[b] = 1'b1;
            end
            part = trial[W-1:0];
        end
        r.remainder = part;
        return r;
    endfunction

    // random wait, with occasional stretches of back-to-back traffic
    task automatic draw_wait(inout int burst, output int cycles);
        if (burst > 0)
        begin
            burst--;
            cycles = 0;
        end
        else
        begin
            if ($urandom_range(0, 39) == 0)
                burst = $urandom_range(20, 60);
            cycles = $urandom_range(0, MAX_WAIT);
        end
    endtask

    task automatic report_mismatch(string field, logic [W-1:0] seen, logic [W-1:0] wanted);
        $display("mismatch on result %0d: %s got %h, expected %h",
                 checked_count, field, seen, wanted);
        error_count++;
    endtask

    task automatic add_division(logic [W-1:0] num, logic [W-1:0] den, logic drain);
        division_t d;
        d.dividend    = num;
        d.divisor     = den;
        d.drain_first = drain;
        division_queue.push_back(d);
        if (den == '0)
            zero_count++;
        if (den[W-1])
            topbit_count++;
        if (drain)
            drain_count++;
    endtask

    // sender: one transfer per handshake, random gap after each item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                quot_rem_due.push_back(divide_restoring(s_tdata[W-1:0], s_tdata[2*W-1:W]));
                sent_count++;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the item until it is taken
            end
            else if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
                s_tdata  <= {$urandom, $urandom};
            end
            else if (division_queue.size() != 0 &&
                     (!division_queue[0].drain_first || quot_rem_due.size() == 0))
            begin
                head = division_queue.pop_front();
                draw_wait(send_burst, next_gap);
                s_tvalid <= 1'b1;
                s_tdata  <= TW'({head.divisor, head.dividend});
                send_gap <= next_gap;
            end
            else
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= {$urandom, $urandom};
            end
        end
    end

    // receiver: check each result against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            stall_now = recv_stall;
            if (m_tvalid && m_tready)
            begin
                got.quotient  = m_tdata[W-1:0];
                got.remainder = m_tdata[2*W-1:W];
                if (quot_rem_due.size() == 0)
                begin
                    $display("unexpected result: quotient %h remainder %h",
                             got.quotient, got.remainder);
                    error_count++;
                end
                else
                begin
                    want = quot_rem_due.pop_front();
                    if (got.quotient !== want.quotient)
                        report_mismatch("quotient", got.quotient, want.quotient);
                    if (got.remainder !== want.remainder)
                        report_mismatch("remainder", got.remainder, want.remainder);
                end
                checked_count++;
                draw_wait(recv_burst, stall_now);
            end
            if (stall_now != 0)
            begin
                m_tready   <= 1'b0;
                recv_stall <= stall_now - 1;
            end
            else
            begin
                m_tready   <= 1'b1;
                recv_stall <= 0;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] ones;
        int           kind;

        ones = '1;

        // directed: field extremes, divide by zero, divisor above dividend, top-bit divisors
        add_division('0, '0, 1'b0);
        add_division(ones, '0, 1'b0);
        add_division(12345, '0, 1'b0);
        add_division('0, ones, 1'b0);
        add_division(ones, ones, 1'b0);
        add_division(ones, 1, 1'b0);
        add_division(1, ones, 1'b0);
        add_division(ones, 2, 1'b0);
        add_division(32'h8000_0000, 32'h8000_0000, 1'b0);
        add_division(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        add_division(ones, 32'h8000_0000, 1'b0);
        add_division(ones, 32'h8000_0001, 1'b0);
        add_division(ones, 32'h7fff_ffff, 1'b0);
        add_division(32'hffff_fffe, ones, 1'b0);
        add_division(32'h8000_0000, 1, 1'b0);
        add_division(100, 7, 1'b0);
        add_division(7, 100, 1'b0);
        add_division(42, 42, 1'b0);
        add_division(1, 1, 1'b0);
        add_division('0, 1, 1'b0);
        add_division(32'haaaa_aaaa, 32'h5555_5555, 1'b0);

        // random mix of operand shapes
        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 99);
            a = $urandom;
            b = $urandom;
            if (kind < 35)
            begin
                // fully random operands
            end
            else if (kind < 50)
                b = $urandom_range(1, 255);
            else if (kind < 60)
            begin
                // divisor at or above the dividend
                a = $urandom >> $urandom_range(0, 31);
                b = $urandom >> $urandom_range(0, 31);
                if (a > b)
                    {a, b} = {b, a};
            end
            else if (kind < 68)
                b = '0;
            else if (kind < 80)
                b = b | 32'h8000_0000;
            else if (kind < 90)
            begin
                // exact multiple, so a zero remainder; the product never wraps
                b = ($urandom >> $urandom_range(16, 31)) | 1;
                a = b * ($urandom >> $urandom_range(16, 31));
            end
            else
            begin
                a = $urandom >> $urandom_range(0, 31);
                b = $urandom >> $urandom_range(0, 31);
            end
            add_division(a, b, (i == 0) || (i % 200 == 199));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (division_queue.size() != 0 || s_tvalid || quot_rem_due.size() != 0)
            @(posedge clk);
        repeat (W + 20) @(posedge clk);

        if (quot_rem_due.size() != 0)
        begin
            $display("%0d results never arrived", quot_rem_due.size());
            error_count++;
        end

        $display("%0d divisions sent (%0d by zero, %0d with divisor MSB set), %0d results checked",
                 sent_count, zero_count, topbit_count, checked_count);
        $display("pipeline drained %0d times mid-run, %0d errors", drain_count, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
